/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers, empty when synthesising.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

/* design/aas_pkg.sv */
// ----------------------------------------------------------------------------
// aas_pkg
// Shared widths, constants, arctangent table and sideband type for the
// aim angle smoother.
// ----------------------------------------------------------------------------
package aas_pkg;

	localparam int XW = 44;
	localparam int ZW = 26;
	localparam int CordicStagesDef = 16;

	localparam logic signed [ZW-1:0] AngHalfTurn = 26'sd11796480;
	localparam logic [15:0] KinvQ16 = 16'd39797;
	localparam logic signed [21:0] PitchLim = 22'sd11392;
	localparam logic signed [21:0] YawLim = 22'sd23040;
	localparam logic signed [21:0] YawTurn = 22'sd46080;

	typedef enum logic [0:0] {
		REG_ENABLE = 1'b0,
		REG_SMOOTHING = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic act;
		logic zero;
		logic signed [XW-1:0] dz;
		logic signed [ZW-1:0] yaw;
		logic signed [15:0] cur_pitch;
		logic signed [15:0] cur_yaw;
	} side_t;

	function automatic logic signed [ZW-1:0] atan_at(input int unsigned i);
		logic signed [ZW-1:0] v;
		case (i)
			0: v = 26'sd2949120;
			1: v = 26'sd1740967;
			2: v = 26'sd919879;
			3: v = 26'sd466945;
			4: v = 26'sd234379;
			5: v = 26'sd117304;
			6: v = 26'sd58666;
			7: v = 26'sd29335;
			8: v = 26'sd14668;
			9: v = 26'sd7334;
			10: v = 26'sd3667;
			11: v = 26'sd1833;
			12: v = 26'sd917;
			13: v = 26'sd458;
			14: v = 26'sd229;
			15: v = 26'sd115;
			16: v = 26'sd57;
			17: v = 26'sd29;
			18: v = 26'sd14;
			19: v = 26'sd7;
			20: v = 26'sd4;
			21: v = 26'sd2;
			22: v = 26'sd1;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

/* design/aas_cordic_stage.sv */
// ----------------------------------------------------------------------------
// aas_cordic_stage
// One registered vectoring CORDIC micro-rotation.
// ----------------------------------------------------------------------------
module aas_cordic_stage #(
	parameter int Idx = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_vld,
	input  logic signed [aas_pkg::XW-1:0] in_x,
	input  logic signed [aas_pkg::XW-1:0] in_y,
	input  logic signed [aas_pkg::ZW-1:0] in_z,
	input  aas_pkg::side_t in_sb,
	output logic out_vld,
	output logic signed [aas_pkg::XW-1:0] out_x,
	output logic signed [aas_pkg::XW-1:0] out_y,
	output logic signed [aas_pkg::ZW-1:0] out_z,
	output aas_pkg::side_t out_sb
);

	logic signed [aas_pkg::XW-1:0] xs, ys;
	logic signed [aas_pkg::ZW-1:0] at;
	logic vld_s1;
	logic signed [aas_pkg::XW-1:0] x_s1, y_s1;
	logic signed [aas_pkg::ZW-1:0] z_s1;
	aas_pkg::side_t sb_s1;

	assign xs = in_x >>> Idx;
	assign ys = in_y >>> Idx;
	assign at = aas_pkg::atan_at(Idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		sb_s1 <= in_sb;
		if (!in_y[aas_pkg::XW-1]) begin
			x_s1 <= in_x + ys;
			y_s1 <= in_y - xs;
			z_s1 <= in_z + at;
		end else begin
			x_s1 <= in_x - ys;
			y_s1 <= in_y + xs;
			z_s1 <= in_z - at;
		end
	end

	assign out_vld = vld_s1;
	assign out_x = x_s1;
	assign out_y = y_s1;
	assign out_z = z_s1;
	assign out_sb = sb_s1;

endmodule

/* design/aas_cordic.sv */
// ----------------------------------------------------------------------------
// aas_cordic
// Chain of registered CORDIC micro-rotations, one per stage.
// ----------------------------------------------------------------------------
module aas_cordic #(
	parameter int Stages = aas_pkg::CordicStagesDef
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_vld,
	input  logic signed [aas_pkg::XW-1:0] in_x,
	input  logic signed [aas_pkg::XW-1:0] in_y,
	input  logic signed [aas_pkg::ZW-1:0] in_z,
	input  aas_pkg::side_t in_sb,
	output logic out_vld,
	output logic signed [aas_pkg::XW-1:0] out_x,
	output logic signed [aas_pkg::ZW-1:0] out_z,
	output aas_pkg::side_t out_sb
);

	logic vld [0:Stages];
	logic signed [aas_pkg::XW-1:0] xc [0:Stages];
	logic signed [aas_pkg::XW-1:0] yc [0:Stages];
	logic signed [aas_pkg::ZW-1:0] zc [0:Stages];
	aas_pkg::side_t sbc [0:Stages];

	assign vld[0] = in_vld;
	assign xc[0] = in_x;
	assign yc[0] = in_y;
	assign zc[0] = in_z;
	assign sbc[0] = in_sb;

	for (genvar g = 0; g < Stages; g++) begin : g_stage
		aas_cordic_stage #(.Idx(g)) u_stage (
			.clk(clk), .arst_n(arst_n),
			.in_vld(vld[g]), .in_x(xc[g]), .in_y(yc[g]), .in_z(zc[g]), .in_sb(sbc[g]),
			.out_vld(vld[g+1]), .out_x(xc[g+1]), .out_y(yc[g+1]), .out_z(zc[g+1]),
			.out_sb(sbc[g+1])
		);
	end

	assign out_vld = vld[Stages];
	assign out_x = xc[Stages];
	assign out_z = zc[Stages];
	assign out_sb = sbc[Stages];

endmodule

/* design/aim_angle_smoother_unit.sv */
// ----------------------------------------------------------------------------
// aim_angle_smoother_unit
// Difference vector to yaw/pitch via two pipelined CORDICs, then smoothing,
// pitch clamp and yaw wrap.
//
//  channel  handshake        payload
//  input    start / busy     engage, target_*, own_*, cur_pitch, cur_yaw
//  result   done (strobe)    write_valid, new_pitch, new_yaw
//  config   wr_en            wr_idx, wr_data
//
// One transaction per cycle; results pass through the two CORDIC chains plus
// pre-rotation, gain multiply and smoothing stages.
// busy is always low. Reset clears valid bits and the config registers.
// Results cannot be held off; done lasts one cycle per transaction.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module aim_angle_smoother_unit #(
	parameter int CORDIC_STAGES = aas_pkg::CordicStagesDef
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  logic [0:0] wr_idx,
	input  logic [8:0] wr_data,
	input  logic start,
	output logic busy,
	input  logic engage,
	input  logic signed [31:0] target_x,
	input  logic signed [31:0] target_y,
	input  logic signed [31:0] target_z,
	input  logic signed [31:0] own_x,
	input  logic signed [31:0] own_y,
	input  logic signed [31:0] own_z,
	input  logic signed [15:0] cur_pitch,
	input  logic signed [15:0] cur_yaw,
	output logic done,
	output logic write_valid,
	output logic signed [14:0] new_pitch,
	output logic signed [15:0] new_yaw
);

	localparam int XW = aas_pkg::XW;
	localparam int ZW = aas_pkg::ZW;

	logic enable_q;
	logic [8:0] smoothing_q;
	logic [8:0] w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			smoothing_q <= '0;
		end else if (wr_en) begin
			case (wr_idx)
				aas_pkg::REG_ENABLE: enable_q <= wr_data[0];
				aas_pkg::REG_SMOOTHING: smoothing_q <= wr_data;
				default: ;
			endcase
		end
	end

	assign w = (smoothing_q > 9'd256) ? 9'd0 : 9'd256 - smoothing_q;
	assign busy = 1'b0;

	// stage 1: differences
	logic vld_s1, act_s1;
	logic signed [32:0] dx_s1, dy_s1, dz_s1;
	logic signed [15:0] cp_s1, cy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1 <= 33'(target_x) - 33'(own_x);
		dy_s1 <= 33'(target_y) - 33'(own_y);
		dz_s1 <= 33'(target_z) - 33'(own_z);
		cp_s1 <= cur_pitch;
		cy_s1 <= cur_yaw;
		act_s1 <= engage && enable_q;
	end

	// stage 2: scale and pre-rotate into the right half plane
	logic signed [XW-1:0] dxw, dyw, dzw;
	logic vld_s2;
	logic signed [XW-1:0] x_s2, y_s2;
	logic signed [ZW-1:0] z_s2;
	aas_pkg::side_t sb_s2;

	assign dxw = {{(XW-41){dx_s1[32]}}, dx_s1, 8'd0};
	assign dyw = {{(XW-41){dy_s1[32]}}, dy_s1, 8'd0};
	assign dzw = {{(XW-41){dz_s1[32]}}, dz_s1, 8'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (dx_s1[32]) begin
			x_s2 <= -dxw;
			y_s2 <= -dyw;
			z_s2 <= dy_s1[32] ? -aas_pkg::AngHalfTurn : aas_pkg::AngHalfTurn;
		end else begin
			x_s2 <= dxw;
			y_s2 <= dyw;
			z_s2 <= '0;
		end
		sb_s2.act <= act_s1;
		sb_s2.zero <= (dx_s1 == '0) && (dy_s1 == '0);
		sb_s2.dz <= dzw;
		sb_s2.yaw <= '0;
		sb_s2.cur_pitch <= cp_s1;
		sb_s2.cur_yaw <= cy_s1;
	end

	// yaw CORDIC
	logic vld_c1;
	logic signed [XW-1:0] x_c1;
	logic signed [ZW-1:0] z_c1;
	aas_pkg::side_t sb_c1;

	aas_cordic #(.Stages(CORDIC_STAGES)) u_cordic_yaw (
		.clk(clk), .arst_n(arst_n),
		.in_vld(vld_s2), .in_x(x_s2), .in_y(y_s2), .in_z(z_s2), .in_sb(sb_s2),
		.out_vld(vld_c1), .out_x(x_c1), .out_z(z_c1), .out_sb(sb_c1)
	);

	// stage 3: gain correction product
	logic vld_s3;
	logic [57:0] prod_s3;
	aas_pkg::side_t sb_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_c1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s3 <= sb_c1.zero ? '0 : 58'(x_c1[41:0]) * 58'(aas_pkg::KinvQ16);
		sb_s3.act <= sb_c1.act;
		sb_s3.zero <= sb_c1.zero;
		sb_s3.dz <= sb_c1.dz;
		sb_s3.yaw <= sb_c1.zero ? '0 : z_c1;
		sb_s3.cur_pitch <= sb_c1.cur_pitch;
		sb_s3.cur_yaw <= sb_c1.cur_yaw;
	end

	// stage 4: round magnitude, set up pitch CORDIC
	logic [57:0] prod_r;
	logic [41:0] mag;
	logic vld_s4;
	logic signed [XW-1:0] x_s4, y_s4;
	aas_pkg::side_t sb_s4;

	assign prod_r = prod_s3 + 58'd32768;
	assign mag = prod_r[57:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		x_s4 <= {{(XW-42){1'b0}}, mag};
		y_s4 <= -sb_s3.dz;
		sb_s4.act <= sb_s3.act;
		sb_s4.zero <= (mag == '0) && (sb_s3.dz == '0);
		sb_s4.dz <= sb_s3.dz;
		sb_s4.yaw <= sb_s3.yaw;
		sb_s4.cur_pitch <= sb_s3.cur_pitch;
		sb_s4.cur_yaw <= sb_s3.cur_yaw;
	end

	// pitch CORDIC
	logic vld_c2;
	logic signed [XW-1:0] x_c2;
	logic signed [ZW-1:0] z_c2;
	aas_pkg::side_t sb_c2;

	aas_cordic #(.Stages(CORDIC_STAGES)) u_cordic_pitch (
		.clk(clk), .arst_n(arst_n),
		.in_vld(vld_s4), .in_x(x_s4), .in_y(y_s4), .in_z('0), .in_sb(sb_s4),
		.out_vld(vld_c2), .out_x(x_c2), .out_z(z_c2), .out_sb(sb_c2)
	);

	// stage 5: smoothing products
	logic signed [ZW:0] pt, dp, dyaw;
	logic signed [9:0] ws;
	logic vld_s5, act_s5;
	logic signed [36:0] pp_s5, py_s5;
	logic signed [15:0] cp_s5, cy_s5;

	assign pt = sb_c2.zero ? '0 : 27'(z_c2);
	assign dp = pt - 27'($signed({sb_c2.cur_pitch, 9'd0}));
	assign dyaw = 27'(sb_c2.yaw) - 27'($signed({sb_c2.cur_yaw, 9'd0}));
	assign ws = $signed({1'b0, w});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= vld_c2;
		end
	end

	always_ff @(posedge clk) begin
		pp_s5 <= 37'(dp) * 37'(ws);
		py_s5 <= 37'(dyaw) * 37'(ws);
		cp_s5 <= sb_c2.cur_pitch;
		cy_s5 <= sb_c2.cur_yaw;
		act_s5 <= sb_c2.act && (x_c2 == x_c2);
	end

	// stage 6: round, clamp, wrap
	logic signed [38:0] accp, accy;
	logic signed [21:0] np, ny, npc, nyw;
	logic done_q, wv_q;
	logic signed [14:0] np_q;
	logic signed [15:0] ny_q;

	assign accp = 39'($signed({cp_s5, 17'd0})) + 39'(pp_s5) + 39'sd65536;
	assign accy = 39'($signed({cy_s5, 17'd0})) + 39'(py_s5) + 39'sd65536;
	assign np = accp[38:17];
	assign ny = accy[38:17];

	always_comb begin
		if (np < -aas_pkg::PitchLim) begin
			npc = -aas_pkg::PitchLim;
		end else if (np > aas_pkg::PitchLim) begin
			npc = aas_pkg::PitchLim;
		end else begin
			npc = np;
		end
		if (ny < -aas_pkg::YawLim) begin
			nyw = ny + aas_pkg::YawTurn;
		end else if (ny > aas_pkg::YawLim) begin
			nyw = ny - aas_pkg::YawTurn;
		end else begin
			nyw = ny;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			wv_q <= 1'b0;
		end else begin
			done_q <= vld_s5;
			wv_q <= vld_s5 && act_s5;
		end
	end

	always_ff @(posedge clk) begin
		np_q <= act_s5 ? npc[14:0] : '0;
		ny_q <= act_s5 ? nyw[15:0] : '0;
	end

	assign done = done_q;
	assign write_valid = wv_q;
	assign new_pitch = np_q;
	assign new_yaw = ny_q;

	`ASSERT_NEVER(a_busy_low, busy, "busy raised")
	`ASSERT_CLK(a_wv_done, write_valid |-> done, "write flagged without result")
	`ASSERT_CLK(a_pitch_lim, done |-> (new_pitch >= -15'sd11392 && new_pitch <= 15'sd11392), "pitch")
	`ASSERT_CLK(a_idle_zero, (done && !write_valid) |-> (new_pitch == '0 && new_yaw == '0), "idle result not zero")

endmodule
